>>> hdl/assert_macros.svh
// Assertion macros shared by the pending request table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Check that a consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/prt_pkg.sv
// Package for the pending request table: command codes, field widths and
// the slot and control structs passed between the controller and the cells.
package prt_pkg;

    localparam int CMD_W   = 3;
    localparam int TAG_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int WORD_W  = 32;
    localparam int OCC_W   = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [WORD_W-1:0] TIMEOUT_RESET = 32'd1000;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [CHAN_W-1:0] channel;
        logic [WORD_W-1:0] param;
        logic [WORD_W-1:0] stamp;
    } slot_t;

    // Broadcast to every cell each cycle
    typedef struct packed {
        logic  shift;
        logic  load;
        slot_t new_slot;
    } cell_ctl_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [CHAN_W-1:0] channel;
        logic [WORD_W-1:0] now;
        logic [WORD_W-1:0] timeout;
    } match_key_t;

endpackage

>>> hdl/prt_cell.sv
// One slot of the pending request table: holds or loads an entry, compares it to
// the key, takes its upper neighbor's on a shift at/above pos. Uses prt_pkg.
module prt_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  prt_pkg::cell_ctl_t   ctl,
    input  prt_pkg::match_key_t  key,
    input  logic [CW-1:0]        pos,
    input  logic                 up_valid,
    input  prt_pkg::slot_t       up_slot,
    output logic                 valid,
    output prt_pkg::slot_t       slot,
    output logic                 hit,
    output logic                 expired
);
    import prt_pkg::*;

    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic            valid_reg;
    logic            valid_next;
    slot_t           slot_reg;
    slot_t           slot_next;
    logic            take_up;
    logic            take_new;
    logic [WORD_W-1:0] age;

    assign take_up  = ctl.shift && (MY_POS >= pos);
    assign take_new = ctl.load && (MY_POS == pos);

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (take_up)
        begin
            valid_next = up_valid;
            slot_next  = up_slot;
        end
        else if (take_new)
        begin
            valid_next = 1'b1;
            slot_next  = ctl.new_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    // Age wraps mod 2^32
    assign age     = key.now - slot_reg.stamp;
    assign hit     = valid_reg && (slot_reg.tag == key.tag) && (slot_reg.channel == key.channel);
    assign expired = valid_reg && (age > key.timeout);
    assign valid   = valid_reg;
    assign slot    = slot_reg;

endmodule

>>> hdl/pending_request_table_top.sv
// Pending request table: controller, statistics counters and a row of
// prt_cell slots. Uses prt_pkg and assert_macros.svh.
//
// Usage: one command item enters on in_valid/in_ready, one result item leaves
// on out_valid/out_ready. The user is to write the sweep timeout through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce
// this. It resets to 1000. Entries live in a row of cells, oldest in cell 0,
// always packed at the low end. Removing an entry shifts every younger cell down
// by one in a single shift of the row.
// Steps from accept to out_valid, each path ending in the finish step:
//   add: an append step, led by an evict step that drops the oldest when full;
//   remove / lookup: a scan from slot 0 up to the match (or the count);
//   sweep: a walk over the live slots, each step dropping or passing one slot;
//   clear statistics and unused codes: the finish step alone.
// The walk takes one slot per cycle; a new item is taken in the cycle after the
// previous result is loaded, so only one item is in work at a time.
// A finished result sits in the output register while the next item is
// accepted and worked on; if the receiver stalls, the controller holds the
// next result until the output register frees up.
// Reset empties the table and zeroes tag counter and statistics.
module pending_request_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [prt_pkg::WORD_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [prt_pkg::CMD_W-1:0]      command,
    input  logic [prt_pkg::CHAN_W-1:0]     channel,
    input  logic [prt_pkg::WORD_W-1:0]     param_word,
    input  logic [prt_pkg::TAG_W-1:0]      request_tag,
    input  logic [prt_pkg::WORD_W-1:0]     now_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [prt_pkg::WORD_W-1:0]     param_out,
    output logic [prt_pkg::TAG_W-1:0]      assigned_tag,
    output logic [prt_pkg::OCC_W-1:0]      occupancy,
    output logic [prt_pkg::WORD_W-1:0]     timeout_total,
    output logic [prt_pkg::WORD_W-1:0]     request_total
);
    import prt_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_APPEND,
        ST_SCAN,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   timeout_reg;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [TAG_W-1:0]    rtag_reg, rtag_next;
    logic [WORD_W-1:0]   pword_reg, pword_next;
    logic [WORD_W-1:0]   now_reg, now_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TAG_W-1:0]    tag_ctr_reg, tag_ctr_next;
    logic [WORD_W-1:0]   expired_reg, expired_next;
    logic [WORD_W-1:0]   added_reg, added_next;
    logic                found_reg, found_next;
    logic [WORD_W-1:0]   pout_reg, pout_next;
    logic [TAG_W-1:0]    atag_reg, atag_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [WORD_W-1:0]   out_pout_reg, out_pout_next;
    logic [TAG_W-1:0]    out_atag_reg, out_atag_next;
    logic [OCC_W-1:0]    out_occ_reg, out_occ_next;
    logic [WORD_W-1:0]   out_exp_reg, out_exp_next;
    logic [WORD_W-1:0]   out_add_reg, out_add_next;

    cell_ctl_t           ctl;
    match_key_t          key;
    logic [CW-1:0]       pos;
    logic [TAG_W-1:0]    tag_inc;

    logic                cell_valid [TABLE_DEPTH];
    slot_t               cell_slot  [TABLE_DEPTH];
    logic                cell_hit   [TABLE_DEPTH];
    logic                cell_exp   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;

    logic                hit_sel;
    logic                exp_sel;
    logic [WORD_W-1:0]   param_sel;

    assign key.tag     = rtag_reg;
    assign key.channel = chan_reg;
    assign key.now     = now_reg;
    assign key.timeout = timeout_reg;

    // Row of cells; the top cell shifts in an empty slot
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic  up_valid;
        slot_t up_slot;
        if (g == TABLE_DEPTH - 1)
        begin : g_top
            assign up_valid = 1'b0;
            assign up_slot  = '0;
        end
        else
        begin : g_mid
            assign up_valid = cell_valid[g+1];
            assign up_slot  = cell_slot[g+1];
        end

        prt_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .key      (key),
            .pos      (pos),
            .up_valid (up_valid),
            .up_slot  (up_slot),
            .valid    (cell_valid[g]),
            .slot     (cell_slot[g]),
            .hit      (cell_hit[g]),
            .expired  (cell_exp[g])
        );

        assign valid_vec[g] = cell_valid[g];
    end

    // Pick the flags and parameter word of the cell under the walk index
    always_comb
    begin
        hit_sel   = 1'b0;
        exp_sel   = 1'b0;
        param_sel = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (k_reg == CW'(i))
            begin
                hit_sel   = hit_sel | cell_hit[i];
                exp_sel   = exp_sel | cell_exp[i];
                param_sel = param_sel | cell_slot[i].param;
            end
        end
    end

    assign tag_inc = tag_ctr_reg + TAG_W'(1);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        chan_next      = chan_reg;
        rtag_next      = rtag_reg;
        pword_next     = pword_reg;
        now_next       = now_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        tag_ctr_next   = tag_ctr_reg;
        expired_next   = expired_reg;
        added_next     = added_reg;
        found_next     = found_reg;
        pout_next      = pout_reg;
        atag_next      = atag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_found_next = out_found_reg;
        out_pout_next  = out_pout_reg;
        out_atag_next  = out_atag_reg;
        out_occ_next   = out_occ_reg;
        out_exp_next   = out_exp_reg;
        out_add_next   = out_add_reg;

        ctl.shift             = 1'b0;
        ctl.load              = 1'b0;
        ctl.new_slot.tag      = tag_ctr_reg;
        ctl.new_slot.channel  = chan_reg;
        ctl.new_slot.param    = pword_reg;
        ctl.new_slot.stamp    = now_reg;
        pos                   = k_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    chan_next  = channel;
                    rtag_next  = request_tag;
                    pword_next = param_word;
                    now_next   = now_ms;
                    k_next     = '0;
                    found_next = 1'b0;
                    pout_next  = '0;
                    atag_next  = '0;
                    case (command)
                        CMD_ADD:
                        begin
                            // Tag zero is never handed out
                            tag_ctr_next = (tag_inc == '0) ? TAG_W'(1) : tag_inc;
                            atag_next    = tag_ctr_next;
                            added_next   = added_reg + WORD_W'(1);
                            state_next   = (count_reg >= FULL) ? ST_EVICT : ST_APPEND;
                        end
                        CMD_REMOVE, CMD_LOOKUP:
                            state_next = ST_SCAN;
                        CMD_SWEEP:
                            state_next = ST_SWEEP;
                        CMD_CLEAR:
                        begin
                            expired_next = '0;
                            added_next   = '0;
                            state_next   = ST_FINISH;
                        end
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_EVICT:
            begin
                // Drop the oldest slot; k_reg is zero here
                ctl.shift  = 1'b1;
                count_next = count_reg - CW'(1);
                state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                ctl.load   = 1'b1;
                pos        = count_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (k_reg >= count_reg)
                    state_next = ST_FINISH;
                else if (hit_sel)
                begin
                    found_next = 1'b1;
                    if (cmd_reg == CMD_LOOKUP)
                        pout_next = param_sel;
                    else
                    begin
                        ctl.shift  = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                    state_next = ST_FINISH;
                end
                else
                    k_next = k_reg + CW'(1);
            end
            ST_SWEEP:
            begin
                if (k_reg >= count_reg)
                    state_next = ST_FINISH;
                else if (exp_sel)
                begin
                    // Hold the index: the next younger entry moves into this slot
                    ctl.shift    = 1'b1;
                    count_next   = count_reg - CW'(1);
                    expired_next = expired_reg + WORD_W'(1);
                end
                else
                    k_next = k_reg + CW'(1);
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_pout_next  = pout_reg;
                    out_atag_next  = atag_reg;
                    out_occ_next   = OCC_W'(count_reg);
                    out_exp_next   = expired_reg;
                    out_add_next   = added_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            k_reg         <= '0;
            count_reg     <= '0;
            tag_ctr_reg   <= '0;
            expired_reg   <= '0;
            added_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
            k_reg         <= k_next;
            count_reg     <= count_next;
            tag_ctr_reg   <= tag_ctr_next;
            expired_reg   <= expired_next;
            added_reg     <= added_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        chan_reg      <= chan_next;
        rtag_reg      <= rtag_next;
        pword_reg     <= pword_next;
        now_reg       <= now_next;
        found_reg     <= found_next;
        pout_reg      <= pout_next;
        atag_reg      <= atag_next;
        out_found_reg <= out_found_next;
        out_pout_reg  <= out_pout_next;
        out_atag_reg  <= out_atag_next;
        out_occ_reg   <= out_occ_next;
        out_exp_reg   <= out_exp_next;
        out_add_reg   <= out_add_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_found_reg;
    assign param_out     = out_pout_reg;
    assign assigned_tag  = out_atag_reg;
    assign occupancy     = out_occ_reg;
    assign timeout_total = out_exp_reg;
    assign request_total = out_add_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL)
    `ASSERT_ALWAYS(a_valid_count, clk, rst_n, $countones(valid_vec) == count_reg)
    `ASSERT_ALWAYS(a_valid_packed, clk, rst_n, ((valid_vec + TABLE_DEPTH'(1)) & valid_vec) == '0)
    `ASSERT_ALWAYS(a_walk_bound, clk, rst_n, !((state_reg == ST_SCAN) || (state_reg == ST_SWEEP)) || (k_reg <= count_reg))

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for pending_request_table_top: random and directed commands
// are checked against a built-in model of the request table. Depends on prt_pkg.
module testbench;
    import prt_pkg::*;

    localparam int DEPTH         = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_FIRST    = 150;
    localparam int HOLD_SECOND   = 1300;
    localparam logic [CMD_W-1:0]  CMD_IDLE_LO = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_IDLE_HI = 3'd7;
    localparam logic [CHAN_W-1:0] CHURN_CHAN  = 8'h5A;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAN_W-1:0] chan;
        logic [WORD_W-1:0] pword;
        logic [TAG_W-1:0]  tag;
        logic [WORD_W-1:0] now;
    } req_item_t;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] pout;
        logic [TAG_W-1:0]  atag;
        logic [OCC_W-1:0]  occ;
        logic [WORD_W-1:0] expired;
        logic [WORD_W-1:0] added;
    } table_reply_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [CHAN_W-1:0] chan;
    } tag_key_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [WORD_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              found;
    logic [WORD_W-1:0] param_out;
    logic [TAG_W-1:0]  assigned_tag;
    logic [OCC_W-1:0]  occupancy;
    logic [WORD_W-1:0] timeout_total;
    logic [WORD_W-1:0] request_total;
    req_item_t         cur_item = '0;

    pending_request_table_top #(.TABLE_DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (cur_item.cmd),
        .channel      (cur_item.chan),
        .param_word   (cur_item.pword),
        .request_tag  (cur_item.tag),
        .now_ms       (cur_item.now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .param_out    (param_out),
        .assigned_tag (assigned_tag),
        .occupancy    (occupancy),
        .timeout_total(timeout_total),
        .request_total(request_total)
    );

    always #5 clk = ~clk;

    // Model of the table: live rows packed at the low end, oldest in row 0
    bit [TAG_W-1:0]  row_tag   [DEPTH];
    bit [CHAN_W-1:0] row_chan  [DEPTH];
    bit [WORD_W-1:0] row_param [DEPTH];
    bit [WORD_W-1:0] row_stamp [DEPTH];
    int              row_count = 0;
    bit [TAG_W-1:0]  tag_next = '0;
    bit [WORD_W-1:0] expired_total = '0;
    bit [WORD_W-1:0] added_total = '0;
    bit [WORD_W-1:0] timeout_cfg = TIMEOUT_RESET;
    int              evictions = 0;
    int              swept_rows = 0;
    int              tag_wraps = 0;

    req_item_t       cmd_queue [$];
    table_reply_t    replies_due [$];
    table_reply_t    reply_want;
    tag_key_t        recent [$];
    bit [TAG_W-1:0]  tag_guess = '0;
    bit [WORD_W-1:0] clock_ms = '0;
    bit              calm = 1'b0;
    bit              in_taken = 1'b0;
    bit              out_taken = 1'b0;
    int              send_gap = 0;
    int              hold_left = 0;
    int              holds_done = 0;
    int              items_sent = 0;
    int              results_done = 0;
    int              fault_count = 0;

    function automatic void drop_row(int slot);
        for (int i = slot; i + 1 < row_count; i++)
        begin
            row_tag[i]   = row_tag[i + 1];
            row_chan[i]  = row_chan[i + 1];
            row_param[i] = row_param[i + 1];
            row_stamp[i] = row_stamp[i + 1];
        end
        row_count--;
    endfunction

    function automatic table_reply_t predict_reply(req_item_t it);
        table_reply_t    r;
        int              hit;
        int              i;
        bit [WORD_W-1:0] age;
        r = '0;
        hit = -1;
        for (i = 0; i < row_count; i++)
        begin
            if (hit < 0 && row_tag[i] == it.tag && row_chan[i] == it.chan)
                hit = i;
        end
        case (it.cmd)
            CMD_ADD:
            begin
                if (row_count >= DEPTH)
                begin
                    drop_row(0);
                    evictions++;
                end
                tag_next = tag_next + 1'b1;
                if (tag_next == 0)
                begin
                    tag_next = TAG_W'(1);
                    tag_wraps++;
                end
                row_tag[row_count]   = tag_next;
                row_chan[row_count]  = it.chan;
                row_param[row_count] = it.pword;
                row_stamp[row_count] = it.now;
                row_count++;
                added_total++;
                r.atag = tag_next;
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    drop_row(hit);
                    r.found = 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    r.pout = row_param[hit];
                end
            end
            CMD_SWEEP:
            begin
                // Stay on the same row after a drop: a younger entry moved into it
                i = 0;
                while (i < row_count)
                begin
                    age = it.now - row_stamp[i];
                    if (age > timeout_cfg)
                    begin
                        drop_row(i);
                        expired_total++;
                        swept_rows++;
                    end
                    else
                        i++;
                end
            end
            CMD_CLEAR:
            begin
                expired_total = '0;
                added_total = '0;
            end
            default:
            begin
            end
        endcase
        r.occ = OCC_W'(row_count);
        r.expired = expired_total;
        r.added = added_total;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_item(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] chan,
                                       logic [WORD_W-1:0] pword, logic [TAG_W-1:0] tag,
                                       logic [WORD_W-1:0] now);
        req_item_t it;
        it = '{cmd, chan, pword, tag, now};
        cmd_queue.push_back(it);
        items_sent++;
        // Track the tag the block will hand out, so removes can aim at live entries
        if (cmd == CMD_ADD)
        begin
            tag_guess = tag_guess + 1'b1;
            if (tag_guess == 0)
                tag_guess = TAG_W'(1);
            recent.push_back('{tag_guess, chan});
            if (recent.size() > DEPTH)
                void'(recent.pop_front());
        end
    endfunction

    task automatic queue_random(int count);
        int              r;
        int              pick;
        logic [TAG_W-1:0]  t;
        logic [CHAN_W-1:0] c;
        repeat (count)
        begin
            clock_ms = clock_ms + $urandom_range(0, 40);
            r = $urandom_range(0, 99);
            if (recent.size() > 0 && $urandom_range(0, 4) != 0)
            begin
                pick = $urandom_range(0, recent.size() - 1);
                t = recent[pick].tag;
                c = recent[pick].chan;
            end
            else
            begin
                t = TAG_W'($urandom);
                c = CHAN_W'($urandom);
            end
            if (r < 38)
                queue_item(CMD_ADD, CHAN_W'($urandom_range(0, 3)), $urandom,
                           TAG_W'($urandom), clock_ms);
            else if (r < 58)
                queue_item(CMD_REMOVE, c, $urandom, t, clock_ms);
            else if (r < 78)
                queue_item(CMD_LOOKUP, c, $urandom, t, clock_ms);
            else if (r < 90)
                queue_item(CMD_SWEEP, c, $urandom, t,
                           ($urandom_range(0, 9) == 0) ? $urandom : clock_ms);
            else if (r < 94)
                queue_item(CMD_CLEAR, CHAN_W'($urandom), $urandom, TAG_W'($urandom),
                           $urandom);
            else if (r < 97)
                queue_item(CMD_W'($urandom_range(CMD_IDLE_HI, CMD_IDLE_LO)),
                           CHAN_W'($urandom), $urandom, TAG_W'($urandom), $urandom);
            else
                queue_item(CMD_ADD, CHAN_W'($urandom), $urandom, TAG_W'($urandom),
                           $urandom);
        end
    endtask

    task automatic wait_drained();
        while (results_done < items_sent)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_timeout(logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        timeout_cfg = value;
    endtask

    task automatic check_field(string what, logic [WORD_W-1:0] want_v, logic [WORD_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime,
                         want_v, got_v);
        end
    endtask

    // Sender: hold each item until taken, then idle for a random gap unless calm
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (in_valid && !calm)
                send_gap = pick_gap();
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                cur_item <= cmd_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus two long hold-offs that back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (holds_done < 2 &&
                results_done >= ((holds_done == 0) ? HOLD_FIRST : HOLD_SECOND))
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            else if (hold_left == 0 && !calm && (out_taken || $urandom_range(0, 15) == 0))
                hold_left = pick_gap();
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: check results in order, predict each accepted item
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            results_done++;
            if (replies_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result at %0t with no item outstanding", $realtime);
            end
            else
            begin
                reply_want = replies_due.pop_front();
                check_field("found", WORD_W'(reply_want.found), WORD_W'(found));
                check_field("param_out", reply_want.pout, param_out);
                check_field("assigned_tag", WORD_W'(reply_want.atag), WORD_W'(assigned_tag));
                check_field("occupancy", WORD_W'(reply_want.occ), WORD_W'(occupancy));
                check_field("timeout_total", reply_want.expired, timeout_total);
                check_field("request_total", reply_want.added, request_total);
            end
        end
        if (rst_n && in_valid && in_ready)
            replies_due.push_back(predict_reply(cur_item));
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [TAG_W-1:0]  marker_tag;
        logic [WORD_W-1:0] marker_param;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, field extremes, boundaries, compaction, idle codes
        queue_item(CMD_LOOKUP, 8'h00, 32'h0, 8'h00, 32'h0);
        queue_item(CMD_REMOVE, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_item(CMD_SWEEP, 8'h00, 32'h0, 8'h00, 32'hFFFF_FFFF);
        queue_item(CMD_ADD, 8'h00, 32'h0, 8'h00, 32'h0);
        queue_item(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_item(CMD_LOOKUP, 8'h00, 32'h0, 8'd1, 32'h0);
        queue_item(CMD_LOOKUP, 8'hFF, 32'h0, 8'd2, 32'h0);
        queue_item(CMD_LOOKUP, 8'h00, 32'h0, 8'd2, 32'h0);
        // Age exactly at the timeout stays; the wrapped one just past it goes
        queue_item(CMD_SWEEP, 8'h00, 32'h0, 8'h00, 32'd1000);
        queue_item(CMD_REMOVE, 8'h00, 32'h0, 8'd1, 32'h0);
        queue_item(CMD_REMOVE, 8'h00, 32'h0, 8'd1, 32'h0);
        queue_item(CMD_IDLE_LO, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_item(CMD_IDLE_LO + 3'd1, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_item(CMD_IDLE_HI, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_item(CMD_ADD, 8'd3, 32'h1234_5678, 8'h00, 32'd2000);
        queue_item(CMD_ADD, 8'd3, 32'h9ABC_DEF0, 8'h00, 32'd2000);
        queue_item(CMD_ADD, 8'd3, 32'h0F0F_0F0F, 8'h00, 32'd2000);
        queue_item(CMD_REMOVE, 8'd3, 32'h0, 8'd4, 32'h0);
        queue_item(CMD_LOOKUP, 8'd3, 32'h0, 8'd5, 32'h0);
        queue_item(CMD_CLEAR, 8'h00, 32'h0, 8'h00, 32'h0);
        // Two expiring entries back to back: the shifted one must be tested too
        queue_item(CMD_SWEEP, 8'h00, 32'h0, 8'h00, 32'd3001);
        queue_item(CMD_ADD, 8'd1, 32'hA5A5_5A5A, 8'h00, 32'd3001);
        wait_drained();

        set_timeout(32'd200);
        clock_ms = 32'd5000;
        queue_random(400);
        wait_drained();

        // No idling here; nothing expires, so the table fills and evicts
        calm = 1'b1;
        set_timeout(32'hFFFF_FFFF);
        queue_random(250);
        wait_drained();
        calm = 1'b0;

        // Churn one channel through a full tag cycle while a marker entry stays,
        // so the marker's tag comes round again as a duplicate
        set_timeout(32'd0);
        clock_ms = clock_ms + 100;
        queue_item(CMD_SWEEP, 8'h00, $urandom, TAG_W'($urandom), clock_ms);
        marker_param = $urandom;
        queue_item(CMD_ADD, CHURN_CHAN, marker_param, TAG_W'($urandom), clock_ms);
        marker_tag = tag_guess;
        repeat (254)
        begin
            queue_item(CMD_ADD, CHURN_CHAN, $urandom, TAG_W'($urandom), clock_ms);
            if ($urandom_range(0, 3) == 0)
                queue_item(CMD_LOOKUP, CHURN_CHAN, $urandom, tag_guess, clock_ms);
            if ($urandom_range(0, 9) == 0)
                queue_item(CMD_SWEEP, CHAN_W'($urandom), $urandom, TAG_W'($urandom),
                           clock_ms);
            queue_item(CMD_REMOVE, CHURN_CHAN, $urandom, tag_guess, clock_ms);
        end
        queue_item(CMD_ADD, CHURN_CHAN, $urandom, TAG_W'($urandom), clock_ms);
        queue_item(CMD_LOOKUP, CHURN_CHAN, $urandom, marker_tag, clock_ms);
        queue_item(CMD_REMOVE, CHURN_CHAN, $urandom, marker_tag, clock_ms);
        queue_item(CMD_LOOKUP, CHURN_CHAN, $urandom, marker_tag, clock_ms);
        queue_item(CMD_REMOVE, CHURN_CHAN, $urandom, marker_tag, clock_ms);
        queue_item(CMD_LOOKUP, CHURN_CHAN, $urandom, marker_tag, clock_ms);
        queue_item(CMD_ADD, CHURN_CHAN, $urandom, TAG_W'($urandom), clock_ms);
        queue_item(CMD_SWEEP, CHAN_W'($urandom), $urandom, TAG_W'($urandom), clock_ms + 1);
        wait_drained();

        // Time runs across the 32-bit wrap
        set_timeout(32'd100);
        clock_ms = 32'hFFFF_F800;
        queue_random(350);
        wait_drained();

        $display("summary: %0d commands checked over five timeout settings, %0d long stalls",
                 results_done, holds_done);
        $display("summary: %0d evictions, %0d entries expired, tag counter wrapped %0d times",
                 evictions, swept_rows, tag_wraps);
        if (fault_count == 0 && replies_due.size() == 0 && results_done == items_sent)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
